[rtl/spq_pkg.sv]
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic insert_en;
    logic remove_en;
    logic load_result;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

[rtl/spq_ctrl.sv]
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_kind,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HELD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_tready  = (state_r == ST_IDLE) || out_tready;
  assign out_tvalid = (state_r == ST_HELD);
  assign accept     = in_tvalid && in_tready;

  assign cmd.insert_en   = accept && (in_kind == KIND_INSERT) && !stat.full;
  assign cmd.remove_en   = accept && (in_kind == KIND_REMOVE) && !stat.empty;
  assign cmd.load_result = accept;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HELD;
      end
      ST_HELD: begin
        if (accept) state_nxt = ST_HELD;
        else if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/spq_datapath.sv]
module spq_datapath
  import spq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  spq_cmd_t           cmd,
  input  logic [ID_W-1:0]    in_entry_id,
  input  logic [PRIO_W-1:0]  in_priority,
  output spq_stat_t          stat,
  output logic               res_ok,
  output logic [ID_W-1:0]    res_removed_id,
  output logic [ID_W-1:0]    res_head_id,
  output logic [PRIO_W-1:0]  res_head_priority,
  output logic [COUNT_W-1:0] res_count,
  output logic               res_is_empty
);

  logic [ID_W-1:0]   slot_id_r   [CAPACITY];
  logic [PRIO_W-1:0] slot_prio_r [CAPACITY];
  logic [ID_W-1:0]   slot_id_nxt   [CAPACITY];
  logic [PRIO_W-1:0] slot_prio_nxt [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              ok_r;
  logic [ID_W-1:0]   removed_r;

  assign stat.full  = (cnt_r == CNT_W'(CAPACITY));
  assign stat.empty = (cnt_r == '0);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_slot
      // slot holds an entry that stays ahead of the new one
      assign ge[g] = (CNT_W'(g) < cnt_r) && (slot_prio_r[g] >= in_priority);

      if (g == 0) begin : g_head
        always_comb begin
          slot_id_nxt[g]   = slot_id_r[g];
          slot_prio_nxt[g] = slot_prio_r[g];
          if (cmd.insert_en) begin
            if (!ge[g]) begin
              slot_id_nxt[g]   = in_entry_id;
              slot_prio_nxt[g] = in_priority;
            end
          end else if (cmd.remove_en) begin
            if (CAPACITY > 1) begin
              slot_id_nxt[g]   = slot_id_r[g+1];
              slot_prio_nxt[g] = slot_prio_r[g+1];
            end
          end
        end
      end else if (g == CAPACITY - 1) begin : g_tail
        always_comb begin
          slot_id_nxt[g]   = slot_id_r[g];
          slot_prio_nxt[g] = slot_prio_r[g];
          if (cmd.insert_en && !ge[g]) begin
            if (ge[g-1]) begin
              slot_id_nxt[g]   = in_entry_id;
              slot_prio_nxt[g] = in_priority;
            end else begin
              slot_id_nxt[g]   = slot_id_r[g-1];
              slot_prio_nxt[g] = slot_prio_r[g-1];
            end
          end
        end
      end else begin : g_mid
        always_comb begin
          slot_id_nxt[g]   = slot_id_r[g];
          slot_prio_nxt[g] = slot_prio_r[g];
          if (cmd.insert_en) begin
            if (!ge[g]) begin
              if (ge[g-1]) begin
                slot_id_nxt[g]   = in_entry_id;
                slot_prio_nxt[g] = in_priority;
              end else begin
                slot_id_nxt[g]   = slot_id_r[g-1];
                slot_prio_nxt[g] = slot_prio_r[g-1];
              end
            end
          end else if (cmd.remove_en) begin
            slot_id_nxt[g]   = slot_id_r[g+1];
            slot_prio_nxt[g] = slot_prio_r[g+1];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.insert_en || cmd.remove_en) begin
          slot_id_r[g]   <= slot_id_nxt[g];
          slot_prio_r[g] <= slot_prio_nxt[g];
        end
      end
    end
  endgenerate

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.insert_en) cnt_nxt = cnt_r + CNT_W'(1);
    else if (cmd.remove_en) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      ok_r      <= cmd.insert_en || cmd.remove_en;
      removed_r <= cmd.remove_en ? slot_id_r[0] : '0;
    end
  end

  // head comes from the slot row, count from cnt_r; both hold while a result waits
  assign res_ok            = ok_r;
  assign res_removed_id    = removed_r;
  assign res_head_id       = stat.empty ? '0 : slot_id_r[0];
  assign res_head_priority = stat.empty ? '0 : slot_prio_r[0];
  assign res_count         = COUNT_W'(cnt_r);
  assign res_is_empty      = stat.empty;

endmodule

[rtl/stable_priority_queue.sv]
// result: valid in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while out_tready does not stall a pending result;
//   every slot compares and shifts in parallel, so the slot row update sets the rate
// reset: synchronous active-low rst_n empties the queue and drops any pending result;
//   slot contents are not cleared and are only read below the entry count
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_id[15:0], priority_req[23:16]
  input  logic [0:0]            in_tuser,   // kind[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // ok[0], removed_id[16:1], head_id[32:17],
                                            // head_priority[40:33], count[47:41],
                                            // is_empty[48], zero[55:49]
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  logic               res_ok;
  logic [ID_W-1:0]    res_removed_id;
  logic [ID_W-1:0]    res_head_id;
  logic [PRIO_W-1:0]  res_head_priority;
  logic [COUNT_W-1:0] res_count;
  logic               res_is_empty;

  // controller owns the handshake and the pending-result flag
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // sorted slot row, entry count and result registers
  spq_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_entry_id       (in_tdata[15:0]),
    .in_priority       (in_tdata[23:16]),
    .stat              (stat),
    .res_ok            (res_ok),
    .res_removed_id    (res_removed_id),
    .res_head_id       (res_head_id),
    .res_head_priority (res_head_priority),
    .res_count         (res_count),
    .res_is_empty      (res_is_empty)
  );

  // pack result fields, lowest field first, pad to whole bytes
  assign out_tdata = {7'd0, res_is_empty, res_count, res_head_priority,
                      res_head_id, res_removed_id, res_ok};

endmodule

[rtl/spq_checker.sv]
module spq_checker
  import spq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[48] == (out_tdata[47:41] == 7'd0)))
    else $error("is_empty disagrees with count");

  // an empty queue reports a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[48]) |-> (out_tdata[32:17] == 16'd0 && out_tdata[40:33] == 8'd0))
    else $error("empty queue shows a nonzero head");

  // a refused transaction never returns an id
  a_refused_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[16:1] == 16'd0))
    else $error("refused transaction returned an id");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
